// ===== rtl/rcwc_pkg.sv =====
// Shared types, codes and helpers of the Reno congestion window core.
`default_nettype none

package rcwc_pkg;

  localparam int WIN_W       = 32;
  localparam int SEG_W       = 16;
  localparam int ACK_FIELD_W = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;

  localparam logic [1:0] CMD_OBSERVE = 2'd0;
  localparam logic [1:0] CMD_START   = 2'd1;
  localparam logic [1:0] CMD_REINIT  = 2'd2;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_SEND = 2'd1;
  localparam logic [1:0] ACT_RETX = 2'd2;

  localparam logic [1:0] PH_SLOW  = 2'd0;
  localparam logic [1:0] PH_AVOID = 2'd1;
  localparam logic [1:0] PH_RECOV = 2'd2;

  localparam logic [1:0] DUP_MAX = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_WIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_THR = 2'd2;

  localparam logic [SEG_W-1:0] SEG_RESET      = 16'd1375;
  localparam logic [WIN_W-1:0] INIT_WIN_RESET = 32'd1375;
  localparam logic [WIN_W-1:0] INIT_THR_RESET = 32'd65535;

  typedef struct packed {
    logic load;
    logic decide;
    logic div_start;
    logic div_apply;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_busy;
  } dp_status_t;

  function automatic logic [WIN_W-1:0] sat_add(input logic [WIN_W-1:0] a,
                                               input logic [WIN_W-1:0] b);
    logic [WIN_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[WIN_W] ? {WIN_W{1'b1}} : sum[WIN_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rcwc_div.sv =====
// Radix-2 restoring divider for the congestion avoidance increment.
`default_nettype none

module rcwc_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [rcwc_pkg::WIN_W-1:0] dividend,
  input  wire logic [rcwc_pkg::WIN_W-1:0] divisor,
  output logic                           done,
  output logic [rcwc_pkg::WIN_W-1:0]     quotient
);

  localparam int W     = rcwc_pkg::WIN_W;
  localparam int CNT_W = $clog2(W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     dsr;
  logic [W:0]       shifted;
  logic [W:0]       diff;

  assign shifted = {rem, quotient[W-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (!diff[W]) begin
          rem <= diff[W-1:0];
        end else begin
          rem <= shifted[W-1:0];
        end
        quotient <= {quotient[W-2:0], ~diff[W]};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rcwc_datapath.sv =====
// Datapath: configuration, congestion state, update rules, divider and result register.
`default_nettype none

module rcwc_datapath #(
  parameter int SEQ_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [rcwc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rcwc_pkg::WIN_W-1:0]          cfg_data,
  input  wire logic [1:0]                          s_tuser,
  input  wire logic [rcwc_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  wire rcwc_pkg::dp_cmd_t                   cmd,
  output rcwc_pkg::dp_status_t                     status,
  input  wire logic                                m_tready,
  output logic                                     m_tvalid,
  output logic [rcwc_pkg::OUT_TDATA_W-1:0]         m_tdata
);

  localparam int W     = rcwc_pkg::WIN_W;
  localparam int SW    = rcwc_pkg::SEG_W;
  localparam int ACK_W = (SEQ_WIDTH < rcwc_pkg::ACK_FIELD_W) ? SEQ_WIDTH
                                                             : rcwc_pkg::ACK_FIELD_W;

  logic [SW-1:0]    seg;
  logic [W-1:0]     init_win;
  logic [W-1:0]     init_thr;
  logic [W-1:0]     win;
  logic [W-1:0]     thr;
  logic [1:0]       phase;
  logic [1:0]       dup;
  logic [ACK_W-1:0] prev_ack;
  logic [1:0]       act;
  logic [1:0]       cmd_r;
  logic [ACK_W-1:0] ack_r;
  logic             tmo_r;
  logic [2*SW-1:0]  sq;

  logic [W-1:0] win_next;
  logic [W-1:0] thr_next;
  logic [1:0]   phase_next;
  logic [1:0]   dup_next;
  logic [1:0]   act_next;

  logic         ack_eq;
  logic         ack_gt;
  logic [W-1:0] seg_w;
  logic [W-1:0] seg3;
  logic [W-1:0] half;
  logic [W-1:0] win_seg;
  logic [1:0]   dup_inc;
  logic [W-1:0] rec_floor;
  logic [W-1:0] rec_thr;
  logic [W-1:0] rec_win;
  logic         div_done;
  logic [W-1:0] quotient;

  assign ack_eq    = (ack_r == prev_ack);
  assign ack_gt    = (ack_r > prev_ack);
  assign seg_w     = W'(seg);
  assign seg3      = seg_w + W'({seg, 1'b0});
  assign half      = win >> 1;
  assign win_seg   = rcwc_pkg::sat_add(win, seg_w);
  assign dup_inc   = (dup == rcwc_pkg::DUP_MAX) ? dup : dup + 2'd1;
  assign rec_floor = (phase == rcwc_pkg::PH_AVOID) ? seg3 : seg_w;
  assign rec_thr   = (half > rec_floor) ? half : rec_floor;
  assign rec_win   = rcwc_pkg::sat_add(rec_thr, seg3);

  assign status.need_div = (cmd_r == rcwc_pkg::CMD_OBSERVE) && !tmo_r &&
                           (phase == rcwc_pkg::PH_AVOID) && ack_gt;
  assign status.div_done = div_done;
  assign status.out_busy = m_tvalid && !m_tready;

  always_comb begin
    logic [1:0] d;
    d          = dup;
    win_next   = win;
    thr_next   = thr;
    phase_next = phase;
    dup_next   = dup;
    act_next   = rcwc_pkg::ACT_NONE;
    case (cmd_r)
      rcwc_pkg::CMD_START: begin
        dup_next = 2'd0;
        act_next = rcwc_pkg::ACT_SEND;
      end
      rcwc_pkg::CMD_REINIT: begin
        win_next   = init_win;
        thr_next   = init_thr;
        phase_next = rcwc_pkg::PH_SLOW;
        dup_next   = 2'd0;
      end
      rcwc_pkg::CMD_OBSERVE: begin
        if (tmo_r) begin
          thr_next   = (half > seg_w) ? half : seg_w;
          win_next   = seg_w;
          dup_next   = 2'd0;
          phase_next = rcwc_pkg::PH_SLOW;
          act_next   = rcwc_pkg::ACT_RETX;
        end else if (phase == rcwc_pkg::PH_RECOV) begin
          if (ack_eq) begin
            dup_next = dup_inc;
            win_next = win_seg;
            act_next = rcwc_pkg::ACT_SEND;
          end else if (ack_gt) begin
            win_next   = thr;
            dup_next   = 2'd0;
            phase_next = rcwc_pkg::PH_AVOID;
          end
        end else begin
          if (ack_eq) begin
            d = dup_inc;
          end else if (ack_gt) begin
            win_next = win_seg;
            if (win_seg >= thr) begin
              phase_next = rcwc_pkg::PH_AVOID;
            end
            d        = 2'd0;
            act_next = rcwc_pkg::ACT_SEND;
          end
          dup_next = d;
          if (d == rcwc_pkg::DUP_MAX) begin
            thr_next   = rec_thr;
            win_next   = rec_win;
            dup_next   = 2'd0;
            phase_next = rcwc_pkg::PH_RECOV;
            act_next   = rcwc_pkg::ACT_RETX;
          end
        end
      end
      default: begin
        act_next = rcwc_pkg::ACT_NONE;
      end
    endcase
  end

  rcwc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sq),
    .divisor  (win),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seg      <= rcwc_pkg::SEG_RESET;
      init_win <= rcwc_pkg::INIT_WIN_RESET;
      init_thr <= rcwc_pkg::INIT_THR_RESET;
      win      <= W'(rcwc_pkg::SEG_RESET);
      thr      <= rcwc_pkg::INIT_THR_RESET;
      phase    <= rcwc_pkg::PH_SLOW;
      dup      <= 2'd0;
      prev_ack <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          rcwc_pkg::CFG_SEGMENT:  seg      <= cfg_data[SW-1:0];
          rcwc_pkg::CFG_INIT_WIN: init_win <= cfg_data;
          rcwc_pkg::CFG_INIT_THR: init_thr <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.decide) begin
        win   <= win_next;
        thr   <= thr_next;
        phase <= phase_next;
        dup   <= dup_next;
        if (cmd_r == rcwc_pkg::CMD_OBSERVE || cmd_r == rcwc_pkg::CMD_START) begin
          prev_ack <= ack_r;
        end
      end
      if (cmd.div_apply) begin
        win      <= rcwc_pkg::sat_add(win, quotient);
        dup      <= 2'd0;
        prev_ack <= ack_r;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= s_tuser;
      ack_r <= s_tdata[ACK_W-1:0];
      tmo_r <= s_tdata[rcwc_pkg::ACK_FIELD_W];
      sq    <= seg * seg;
    end
    if (cmd.decide) begin
      act <= act_next;
    end
    if (cmd.div_apply) begin
      act <= rcwc_pkg::ACT_SEND;
    end
    if (cmd.out_load) begin
      m_tdata <= {2'b00, dup, phase, thr, win, act};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rcwc_ctrl.sv =====
// Controller state machine that sequences each transaction through the datapath.
`default_nettype none

module rcwc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire rcwc_pkg::dp_status_t status,
  output rcwc_pkg::dp_cmd_t         cmd
);

  typedef enum logic [1:0] {
    IDLE,
    DECIDE,
    DIVIDE,
    WRITE
  } state_t;

  state_t state;

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == IDLE) && s_tvalid && s_tready;
    cmd.decide    = (state == DECIDE) && !status.need_div;
    cmd.div_start = (state == DECIDE) && status.need_div;
    cmd.div_apply = (state == DIVIDE) && status.div_done;
    cmd.out_load  = (state == WRITE) && !status.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      s_tready <= 1'b1;
    end else begin
      case (state)
        IDLE: begin
          if (s_tvalid && s_tready) begin
            state    <= DECIDE;
            s_tready <= 1'b0;
          end
        end
        DECIDE: begin
          state <= status.need_div ? DIVIDE : WRITE;
        end
        DIVIDE: begin
          if (status.div_done) begin
            state <= WRITE;
          end
        end
        WRITE: begin
          if (!status.out_busy) begin
            state    <= IDLE;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state    <= IDLE;
          s_tready <= 1'b1;
        end
      endcase
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("More than one datapath command in a cycle.");

  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> state == DIVIDE)
    else $error("Divider finished outside the divide state.");

  a_load_closes: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == DECIDE && !s_tready)
    else $error("Accepted transaction did not close the input.");

  a_write_reopens: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> s_tready && state == IDLE)
    else $error("Input not reopened after the result was written.");

endmodule

`default_nettype wire

// ===== rtl/reno_congestion_window_control_core.sv =====
// Top level of the Reno congestion window core: ports, controller and datapath.
`default_nettype none

// Each input transaction produces exactly one result transaction. Transactions
// that need no division go from acceptance to result through accept, update
// and write to the output register. An observe round without a timeout that
// brings a new acknowledgement in congestion avoidance goes through the
// divider: the increment segment_size squared over the window comes from a
// radix-2 divider that resolves one quotient bit per cycle over 32 steps, with
// a step before them to start the divider and one after them to apply its
// quotient. The input is closed while a transaction is being worked on; a
// finished result waits in the output register while the next transaction is
// accepted, and only a full output register holds back the next result.

module reno_congestion_window_control_core #(
  parameter int SEQ_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [rcwc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rcwc_pkg::WIN_W-1:0]          cfg_data,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // tdata: ack_seen[31:0], timed_out[32], zero fill [39:33].
  input  wire logic [rcwc_pkg::IN_TDATA_W-1:0]     s_tdata,
  // tuser: command[1:0].
  input  wire logic [1:0]                          s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // tdata: action[1:0], window_now[33:2], threshold_now[65:34],
  // phase_now[67:66], dup_count_now[69:68], zero fill [71:70].
  output logic [rcwc_pkg::OUT_TDATA_W-1:0]         m_tdata
);

  rcwc_pkg::dp_cmd_t    cmd;
  rcwc_pkg::dp_status_t status;

  rcwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rcwc_datapath #(
    .SEQ_WIDTH (SEQ_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire
